FILE: hdl/sqvs_pkg.sv
`timescale 1ns / 1ps

package sqvs_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEX_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEX_HEIGHT = 1'd1;

   // Command codes
   localparam logic CMD_PLACE = 1'b0;
   localparam logic CMD_RECT  = 1'b1;

   // Corner order
   localparam logic [1:0] CORNER_TL = 2'd0;
   localparam logic [1:0] CORNER_TR = 2'd1;
   localparam logic [1:0] CORNER_BR = 2'd2;
   localparam logic [1:0] CORNER_BL = 2'd3;

   // Quadrant codes of the rotation angle
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // CORDIC rotation, Q30 with a pre-scaled start vector
   localparam int CORDIC_STEPS = 18;
   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic signed [18:0] ONE_Q16 = 19'sd65536;

   // atan(2^-i) in 1/2^24 turn
   localparam logic signed [24:0] ATAN_TURNS [CORDIC_STEPS] = '{
      25'sd2097152, 25'sd1238021, 25'sd654136, 25'sd332050, 25'sd166669,
      25'sd83416, 25'sd41718, 25'sd20860, 25'sd10430, 25'sd5215, 25'sd2608,
      25'sd1304, 25'sd652, 25'sd326, 25'sd163, 25'sd81, 25'sd41, 25'sd20
   };

   // Work carried down the pipeline with one item
   typedef struct {
      logic                cmd;
      logic                rot;
      logic [15:0]         angle;
      logic signed [23:0]  px, py, ax, ay, ox, oy;
      logic signed [15:0]  sw, sh;
      logic [14:0]         sl, stp;
      logic signed [40:0]  ext_x, ext_y;
      logic signed [47:0]  prx, pry;
      logic signed [48:0]  lx [2];
      logic signed [48:0]  ly [2];
      logic [1:0]          quad;
      logic                rzero;
      logic signed [32:0]  cor_x, cor_y;
      logic signed [24:0]  cor_z;
      logic signed [18:0]  cs, sn;
      logic                tneg [4];
      logic [16:0]         tmag [4];
      logic [33:0]         rem  [4];
      logic [17:0]         quo  [4];
      logic                ovf  [4];
      logic signed [17:0]  tc   [4];
      logic signed [67:0]  lxc [2];
      logic signed [67:0]  lxs [2];
      logic signed [67:0]  lyc [2];
      logic signed [67:0]  lys [2];
      logic signed [23:0]  vx [4];
      logic signed [23:0]  vy [4];
   } pipe_type;

   // Clamp a wide coordinate to a 24-bit field
   function automatic logic signed [23:0] sat_coord(input logic signed [55:0] v);
      logic signed [23:0] r;
      if (v > 56'sd8388607) r = 24'sd8388607;
      else if (v < -56'sd8388608) r = -24'sd8388608;
      else r = 24'(v);
      return r;
   endfunction

endpackage

FILE: hdl/sqvs_req_if.sv
`timescale 1ns / 1ps

interface sqvs_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic signed [23:0] place_x;
   logic signed [23:0] place_y;
   logic [14:0]        source_left;
   logic [14:0]        source_top;
   logic signed [15:0] source_width;
   logic signed [15:0] source_height;
   logic signed [23:0] scale_or_width;
   logic signed [23:0] scale_or_height;
   logic signed [23:0] pivot_x;
   logic signed [23:0] pivot_y;
   logic [15:0]        angle;

   modport source (output valid, command, place_x, place_y, source_left, source_top,
                   source_width, source_height, scale_or_width, scale_or_height,
                   pivot_x, pivot_y, angle, input ready);
   modport sink (input valid, command, place_x, place_y, source_left, source_top,
                 source_width, source_height, scale_or_width, scale_or_height,
                 pivot_x, pivot_y, angle, output ready);
endinterface

FILE: hdl/sqvs_rsp_if.sv
`timescale 1ns / 1ps

interface sqvs_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         corner;
   logic signed [23:0] vertex_x;
   logic signed [23:0] vertex_y;
   logic signed [17:0] tex_u;
   logic signed [17:0] tex_v;
   logic               last;

   modport source (output valid, corner, vertex_x, vertex_y, tex_u, tex_v, last,
                   input ready);
   modport sink (input valid, corner, vertex_x, vertex_y, tex_u, tex_v, last,
                 output ready);
endinterface

FILE: hdl/sprite_quad_vertex_setup.sv
`timescale 1ns / 1ps

// Sprite quad vertex setup: each request item yields four corner items (top-left,
// top-right, bottom-right, bottom-left) with saturated Q.F screen position and Q2.16
// texture coordinate. The datapath is a 24-stage pipeline: input capture, products,
// pivot rounding, 18 stages where an 18-step CORDIC and four restoring dividers
// (u and v at both rectangle edges) each take one step, trig fix-up, rotation
// products and final sum. After the final sum stage a quad is loaded into the
// output register when that register is free. The single result port emits one
// corner per cycle while the receiver is ready, so sustained input is one request
// per quad; the pipeline keeps filling while corners are drained. SINE_TABLE_ENTRIES
// must be a power of two. The user must write the texture size registers only while
// the block is empty; the block does not enforce this. A size of 0 acts as 1.
module sprite_quad_vertex_setup
   import sqvs_pkg::*;
#(
   parameter int COORD_FRAC_BITS    = 8,
   parameter int SINE_TABLE_ENTRIES = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [14:0]            csr_wdata,
   sqvs_req_if.sink               req_ch,
   sqvs_rsp_if.source             rsp_ch
);

   localparam int TBL_BITS = $clog2(SINE_TABLE_ENTRIES);
   localparam int CS0      = 3;
   localparam int TRIG_STG = CS0 + CORDIC_STEPS;
   localparam int PROD_STG = TRIG_STG + 1;
   localparam int SUM_STG  = PROD_STG + 1;
   localparam int NST      = SUM_STG + 1;

   logic [14:0] tex_w_ff, tex_h_ff;
   logic [14:0] lane_div [4];

   pipe_type st_ff [NST];
   pipe_type st_in [NST];
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_src;
   logic [NST:0]   adv;

   pipe_type   ser_ff;
   logic       ser_vld_ff;
   logic [1:0] cnt_ff;
   logic       out_load;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tex_w_ff <= 15'd1;
         tex_h_ff <= 15'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TEX_WIDTH:  tex_w_ff <= csr_wdata;
            CSR_TEX_HEIGHT: tex_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Divisor per lane, zero reads as one
   always_comb begin
      lane_div[0] = (tex_w_ff == 15'd0) ? 15'd1 : tex_w_ff;
      lane_div[1] = lane_div[0];
      lane_div[2] = (tex_h_ff == 15'd0) ? 15'd1 : tex_h_ff;
      lane_div[3] = lane_div[2];
   end

   // Stall chain: a stage moves when empty or when the next one moves
   always_comb begin
      adv[NST] = out_load;
      for (int k = NST - 1; k >= 0; k--) adv[k] = !vld_ff[k] || adv[k+1];
   end

   assign vld_src = {vld_ff[NST-2:0], req_ch.valid};
   assign req_ch.ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) if (adv[k]) vld_ff[k] <= vld_src[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NST; k++) if (adv[k]) st_ff[k] <= st_in[k];
   end

   // Stage 0: capture the item
   always_comb begin
      st_in[0]       = st_ff[0];
      st_in[0].cmd   = req_ch.command;
      st_in[0].px    = req_ch.place_x;
      st_in[0].py    = req_ch.place_y;
      st_in[0].sl    = req_ch.source_left;
      st_in[0].stp   = req_ch.source_top;
      st_in[0].sw    = req_ch.source_width;
      st_in[0].sh    = req_ch.source_height;
      st_in[0].ax    = req_ch.scale_or_width;
      st_in[0].ay    = req_ch.scale_or_height;
      st_in[0].ox    = req_ch.pivot_x;
      st_in[0].oy    = req_ch.pivot_y;
      st_in[0].angle = req_ch.angle;
   end

   // Stage 1: extents, pivot products, texel edges, angle decode
   always_comb begin
      logic signed [16:0] t [4];
      logic [23:0]        ph;
      st_in[1] = st_ff[0];
      if (st_ff[0].cmd == CMD_RECT) begin
         st_in[1].ext_x = 41'(st_ff[0].ax);
         st_in[1].ext_y = 41'(st_ff[0].ay);
      end else begin
         st_in[1].ext_x = st_ff[0].sw * st_ff[0].ax;
         st_in[1].ext_y = st_ff[0].sh * st_ff[0].ay;
      end
      st_in[1].prx = st_ff[0].ox * st_ff[0].ax;
      st_in[1].pry = st_ff[0].oy * st_ff[0].ay;
      t[0] = $signed({2'b00, st_ff[0].sl});
      t[1] = $signed({2'b00, st_ff[0].sl}) + 17'(st_ff[0].sw);
      t[2] = $signed({2'b00, st_ff[0].stp});
      t[3] = $signed({2'b00, st_ff[0].stp}) + 17'(st_ff[0].sh);
      for (int l = 0; l < 4; l++) begin
         st_in[1].tneg[l] = t[l][16];
         st_in[1].tmag[l] = t[l][16] ? 17'(-t[l]) : 17'(t[l]);
      end
      st_in[1].rot   = (st_ff[0].cmd == CMD_PLACE) && (st_ff[0].angle != 16'd0);
      ph             = 24'(st_ff[0].angle >> (16 - TBL_BITS)) << (24 - TBL_BITS);
      st_in[1].quad  = ph[23:22];
      st_in[1].rzero = (ph[21:0] == 22'd0);
      st_in[1].cor_z = $signed(25'(ph[21:0]));
   end

   // Stage 2: round pivot, corner offsets, divider and CORDIC start
   always_comb begin
      logic signed [47:0] half, cx, cy;
      logic [33:0]        dlim;
      half     = 48'sd1 <<< (COORD_FRAC_BITS - 1);
      cx       = (st_ff[1].prx + half) >>> COORD_FRAC_BITS;
      cy       = (st_ff[1].pry + half) >>> COORD_FRAC_BITS;
      st_in[2] = st_ff[1];
      st_in[2].lx[0] = -49'(cx);
      st_in[2].lx[1] = 49'(st_ff[1].ext_x) - 49'(cx);
      st_in[2].ly[0] = -49'(cy);
      st_in[2].ly[1] = 49'(st_ff[1].ext_y) - 49'(cy);
      for (int l = 0; l < 4; l++) begin
         dlim             = 34'(lane_div[l]) << 18;
         st_in[2].rem[l]  = 34'({st_ff[1].tmag[l], 16'h0000}) + 34'(lane_div[l] >> 1);
         st_in[2].ovf[l]  = (st_in[2].rem[l] >= dlim);
         st_in[2].quo[l]  = '0;
      end
      st_in[2].cor_x = CORDIC_GAIN;
      st_in[2].cor_y = '0;
   end

   // Stages 3..20: one CORDIC step and one quotient bit per lane each
   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
      always_comb begin
         logic [33:0] dsh;
         st_in[CS0+g] = st_ff[CS0+g-1];
         if (st_ff[CS0+g-1].cor_z >= 0) begin
            st_in[CS0+g].cor_x = st_ff[CS0+g-1].cor_x - (st_ff[CS0+g-1].cor_y >>> g);
            st_in[CS0+g].cor_y = st_ff[CS0+g-1].cor_y + (st_ff[CS0+g-1].cor_x >>> g);
            st_in[CS0+g].cor_z = st_ff[CS0+g-1].cor_z - ATAN_TURNS[g];
         end else begin
            st_in[CS0+g].cor_x = st_ff[CS0+g-1].cor_x + (st_ff[CS0+g-1].cor_y >>> g);
            st_in[CS0+g].cor_y = st_ff[CS0+g-1].cor_y - (st_ff[CS0+g-1].cor_x >>> g);
            st_in[CS0+g].cor_z = st_ff[CS0+g-1].cor_z + ATAN_TURNS[g];
         end
         for (int l = 0; l < 4; l++) begin
            dsh = 34'(lane_div[l]) << (CORDIC_STEPS - 1 - g);
            if (st_ff[CS0+g-1].rem[l] >= dsh) begin
               st_in[CS0+g].rem[l] = st_ff[CS0+g-1].rem[l] - dsh;
               st_in[CS0+g].quo[l][CORDIC_STEPS-1-g] = 1'b1;
            end
         end
      end
   end

   // Trig fix-up by quadrant, texture coordinate clamp
   always_comb begin
      logic signed [18:0] c, s;
      logic [18:0]        qq;
      st_in[TRIG_STG] = st_ff[TRIG_STG-1];
      if (st_ff[TRIG_STG-1].rzero) begin
         c = ONE_Q16;
         s = '0;
      end else begin
         c = 19'((st_ff[TRIG_STG-1].cor_x + 33'sd8192) >>> 14);
         s = 19'((st_ff[TRIG_STG-1].cor_y + 33'sd8192) >>> 14);
      end
      case (st_ff[TRIG_STG-1].quad)
         QUAD_0: begin st_in[TRIG_STG].cs = c;  st_in[TRIG_STG].sn = s;  end
         QUAD_1: begin st_in[TRIG_STG].cs = -s; st_in[TRIG_STG].sn = c;  end
         QUAD_2: begin st_in[TRIG_STG].cs = -c; st_in[TRIG_STG].sn = -s; end
         default: begin st_in[TRIG_STG].cs = s; st_in[TRIG_STG].sn = -c; end
      endcase
      for (int l = 0; l < 4; l++) begin
         qq = {1'b0, st_ff[TRIG_STG-1].quo[l]};
         if (st_ff[TRIG_STG-1].tneg[l]) begin
            st_in[TRIG_STG].tc[l] = (st_ff[TRIG_STG-1].ovf[l] || qq > 19'd131072) ?
                                    -18'sd131072 : 18'(19'd0 - qq);
         end else begin
            st_in[TRIG_STG].tc[l] = (st_ff[TRIG_STG-1].ovf[l] || qq > 19'd131071) ?
                                    18'sd131071 : $signed(st_ff[TRIG_STG-1].quo[l]);
         end
      end
   end

   // Rotation products
   always_comb begin
      st_in[PROD_STG] = st_ff[PROD_STG-1];
      for (int j = 0; j < 2; j++) begin
         st_in[PROD_STG].lxc[j] = st_ff[PROD_STG-1].lx[j] * st_ff[PROD_STG-1].cs;
         st_in[PROD_STG].lxs[j] = st_ff[PROD_STG-1].lx[j] * st_ff[PROD_STG-1].sn;
         st_in[PROD_STG].lyc[j] = st_ff[PROD_STG-1].ly[j] * st_ff[PROD_STG-1].cs;
         st_in[PROD_STG].lys[j] = st_ff[PROD_STG-1].ly[j] * st_ff[PROD_STG-1].sn;
      end
   end

   // Corner sums, round, add position, clamp
   always_comb begin
      logic signed [68:0] rx, ry;
      logic signed [55:0] nx, ny;
      int sx, sy;
      st_in[SUM_STG] = st_ff[SUM_STG-1];
      for (int k = 0; k < 4; k++) begin
         sx = (k == 1 || k == 2) ? 1 : 0;
         sy = (k >= 2) ? 1 : 0;
         if (st_ff[SUM_STG-1].rot) begin
            rx = 69'(st_ff[SUM_STG-1].lxc[sx]) - 69'(st_ff[SUM_STG-1].lys[sy]);
            ry = 69'(st_ff[SUM_STG-1].lxs[sx]) + 69'(st_ff[SUM_STG-1].lyc[sy]);
            rx = (rx + 69'sd32768) >>> 16;
            ry = (ry + 69'sd32768) >>> 16;
            nx = 56'(st_ff[SUM_STG-1].px) + 56'(rx);
            ny = 56'(st_ff[SUM_STG-1].py) + 56'(ry);
         end else begin
            rx = '0;
            ry = '0;
            nx = 56'(st_ff[SUM_STG-1].px) + ((sx == 1) ? 56'(st_ff[SUM_STG-1].ext_x) : '0);
            ny = 56'(st_ff[SUM_STG-1].py) + ((sy == 1) ? 56'(st_ff[SUM_STG-1].ext_y) : '0);
         end
         st_in[SUM_STG].vx[k] = sat_coord(nx);
         st_in[SUM_STG].vy[k] = sat_coord(ny);
      end
   end

   // Output register: hold the quad, step through its corners
   assign out_load = !ser_vld_ff || (rsp_ch.ready && cnt_ff == CORNER_BL);

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_vld_ff <= 1'b0;
         cnt_ff     <= CORNER_TL;
      end else if (out_load) begin
         ser_vld_ff <= vld_ff[NST-1];
         cnt_ff     <= CORNER_TL;
      end else if (rsp_ch.ready) begin
         cnt_ff <= cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) ser_ff <= st_ff[NST-1];
   end

   assign rsp_ch.valid    = ser_vld_ff;
   assign rsp_ch.corner   = cnt_ff;
   assign rsp_ch.vertex_x = ser_ff.vx[cnt_ff];
   assign rsp_ch.vertex_y = ser_ff.vy[cnt_ff];
   assign rsp_ch.tex_u    = (cnt_ff == CORNER_TR || cnt_ff == CORNER_BR) ?
                            ser_ff.tc[1] : ser_ff.tc[0];
   assign rsp_ch.tex_v    = (cnt_ff == CORNER_BR || cnt_ff == CORNER_BL) ?
                            ser_ff.tc[3] : ser_ff.tc[2];
   assign rsp_ch.last     = (cnt_ff == CORNER_BL);

   // Corners advance by one on every item taken mid-quad
   a_corner_step: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && cnt_ff != CORNER_BL |=>
         rsp_ch.valid && cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("corner sequence broken");

   // A waiting corner keeps its index
   a_corner_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(cnt_ff))
      else $error("corner index moved under stall");

   // Input is refused only when the first stage holds an item
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> vld_ff[0])
      else $error("input refused with empty first stage");

   // Quadrant fix-up keeps cosine and sine in range
   a_trig_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[TRIG_STG] |-> st_ff[TRIG_STG].cs <= 19'sd65537 &&
         st_ff[TRIG_STG].cs >= -19'sd65537 && st_ff[TRIG_STG].sn <= 19'sd65537 &&
         st_ff[TRIG_STG].sn >= -19'sd65537)
      else $error("trig value out of range");

endmodule
